### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define HCBP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcbp assertion failed");

// next-cycle implication, disabled in reset
`define HCBP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcbp assertion failed");

`endif

### design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants of the codebook bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_CAP_I    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam logic [5:0] LEN_CAP = 6'(LEN_CAP_I);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [8:0]  entry_count;
        logic [7:0]  symbol;
        logic [5:0]  code_length;
        logic [31:0] code_bits;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       status;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [1:0]  op;
        logic        hit;
        logic [5:0]  len;
        logic [31:0] code;
    } t_job;

endpackage

### design/huffman_codebook_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_codebook_bit_packer
// Huffman encoder with a loadable codebook and an LSB-first byte packer.
// ----------------------------------------------------------------------------
// The block takes a new item in any cycle in which its job queue has room
// and gives out one result per cycle through a registered output while
// i_stall is low. An item yields one result for begin, an unknown symbol or
// a symbol that fills no byte, one plus the code's byte count for a load, one
// per filled byte for a data symbol, and one or two for finish. The first
// result of an item passes through the input register, the job queue, the
// emitter's accumulator and the output register; the codebook lives in
// 256-entry memories whose read data is registered when the item is taken.
module huffman_codebook_bit_packer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  hcbp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output hcbp_pkg::t_out o_data
);
    import hcbp_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job job;
    t_job head;

    hcbp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    hcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    hcbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

### design/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts items, keeps the codebook memories and valid bits, and turns each
// item into a job for the emitter queue.
// ----------------------------------------------------------------------------
module hcbp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hcbp_pkg::t_in i_data,
    input  logic          i_full,
    output logic          o_push,
    output hcbp_pkg::t_job o_job
);
    import hcbp_pkg::*;

    logic [31:0] r_code_mem [256];
    logic [5:0]  r_len_mem  [256];
    logic [255:0] r_entry_valid;

    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic        r_s1_hit;
    logic [5:0]  r_s1_len;
    logic [31:0] r_s1_code;
    logic [31:0] r_rd_code;
    logic [5:0]  r_rd_len;

    logic        accept;
    logic [5:0]  len_c;
    logic [31:0] mask;
    logic [31:0] masked;

    assign o_stall = r_s1_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_s1_valid && !i_full;

    assign len_c  = (i_data.code_length > LEN_CAP) ? LEN_CAP : i_data.code_length;

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            mask[i] = (6'(i) < len_c);
        end
    end

    assign masked = i_data.code_bits & mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_entry_valid <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
            if (accept && i_data.operation == OP_BEGIN) begin
                r_entry_valid <= '0;
            end else if (accept && i_data.operation == OP_LOAD) begin
                r_entry_valid[i_data.symbol] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= i_data.operation;
            r_s1_hit <= r_entry_valid[i_data.symbol];
            r_s1_len <= len_c;
            if (i_data.operation == OP_BEGIN) begin
                r_s1_code <= {24'd0, 8'(i_data.entry_count - 9'd1)};
            end else begin
                r_s1_code <= masked;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_data.operation == OP_LOAD) begin
            r_code_mem[i_data.symbol] <= masked;
            r_len_mem[i_data.symbol]  <= len_c;
        end
        if (accept && i_data.operation == OP_DATA) begin
            r_rd_code <= r_code_mem[i_data.symbol];
            r_rd_len  <= r_len_mem[i_data.symbol];
        end
    end

    always_comb begin
        o_job.op   = r_s1_op;
        o_job.hit  = r_s1_hit;
        o_job.len  = (r_s1_op == OP_DATA) ? r_rd_len : r_s1_len;
        o_job.code = (r_s1_op == OP_DATA) ? r_rd_code : r_s1_code;
    end

endmodule

### design/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short job queue between the front end and the emitter.
// ----------------------------------------------------------------------------
module hcbp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcbp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output hcbp_pkg::t_job o_head
);
    import hcbp_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

### design/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Emitter: holds the partial byte, expands each job into result bytes and
// drives the registered output channel.
// ----------------------------------------------------------------------------
module hcbp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  hcbp_pkg::t_job i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output hcbp_pkg::t_out o_data
);
    import hcbp_pkg::*;

    logic [39:0] r_acc;
    logic [2:0]  r_cnt;
    logic        r_bvalid;
    logic        r_status;
    logic [6:0]  r_pend;
    logic [2:0]  r_pc;
    logic        r_out_valid;
    t_out        r_out;

    logic [39:0] n_acc;
    logic [2:0]  n_cnt;
    logic        n_bvalid;
    logic        n_status;
    logic [6:0]  n_pend;
    logic [2:0]  n_pc;

    logic        emit;
    logic [39:0] sh;
    logic [39:0] rem;
    logic [6:0]  total;
    logic [2:0]  full;
    logic [2:0]  pad;
    logic [6:0]  nbytes;

    assign emit  = (r_cnt != 3'd0) && (!r_out_valid || !i_stall);
    assign o_pop = !i_empty && ((r_cnt == 3'd0) || (r_cnt == 3'd1 && emit));

    assign sh     = ({8'd0, i_head.code} << r_pc) | {33'd0, r_pend};
    assign total  = 7'(r_pc) + 7'(i_head.len);
    assign full   = total[5:3];
    assign rem    = sh >> {full, 3'b000};
    assign pad    = 3'(3'd0 - r_pc);
    assign nbytes = (7'(i_head.len) + 7'd7) >> 3;

    always_comb begin
        n_acc    = '0;
        n_cnt    = 3'd1;
        n_bvalid = 1'b1;
        n_status = 1'b0;
        n_pend   = r_pend;
        n_pc     = r_pc;
        unique case (i_head.op)
            OP_BEGIN: begin
                n_acc  = {32'd0, i_head.code[7:0]};
                n_pend = '0;
                n_pc   = '0;
            end
            OP_LOAD: begin
                n_acc = {i_head.code, 2'b00, i_head.len};
                n_cnt = 3'(7'd1 + nbytes);
            end
            OP_DATA: begin
                if (!i_head.hit) begin
                    n_bvalid = 1'b0;
                    n_status = 1'b1;
                end else if (full == 3'd0) begin
                    n_bvalid = 1'b0;
                    n_pend   = rem[6:0];
                    n_pc     = total[2:0];
                end else begin
                    n_acc  = sh;
                    n_cnt  = full;
                    n_pend = rem[6:0];
                    n_pc   = total[2:0];
                end
            end
            OP_FINISH: begin
                if (r_pc != 3'd0) begin
                    n_acc = {24'd0, 5'd0, pad, 1'b0, r_pend};
                    n_cnt = 3'd2;
                end else begin
                    n_acc = {37'd0, pad};
                end
                n_pend = '0;
                n_pc   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= '0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cnt  <= n_cnt;
                r_pend <= n_pend;
                r_pc   <= n_pc;
            end else if (emit) begin
                r_cnt <= r_cnt - 3'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_acc    <= n_acc;
            r_bvalid <= n_bvalid;
            r_status <= n_status;
        end else if (emit) begin
            r_acc <= r_acc >> 8;
        end
        if (emit) begin
            r_out.out_byte   <= r_acc[7:0];
            r_out.byte_valid <= r_bvalid;
            r_out.status     <= r_status;
            r_out.last       <= (r_cnt == 3'd1);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### design/hcbp_checker.sv
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on the result channel of the bit packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_res_valid,
    input logic           i_stall,
    input hcbp_pkg::t_out i_res_data
);
    import hcbp_pkg::*;

    `HCBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_res_valid && i_stall,
        i_res_valid && $stable(i_res_data))
    `HCBP_ASSERT_NOW(a_empty_byte_zero, i_clk, i_rst_n,
        i_res_valid && !i_res_data.byte_valid, i_res_data.out_byte == 8'd0)
    `HCBP_ASSERT_NOW(a_error_alone, i_clk, i_rst_n, i_res_valid && i_res_data.status,
        i_res_data.last && !i_res_data.byte_valid)

endmodule

bind huffman_codebook_bit_packer hcbp_checker u_hcbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_valid),
    .i_stall     (i_stall),
    .i_res_data  (o_data)
);
